/* src/feg_pkg.sv */
// shared types and constants for the fade envelope gain block
`timescale 1ns / 1ps
package feg_pkg;
    localparam logic [1:0] MODE_FRAME  = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_FADE   = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    localparam int CLK_BITS = 32;
endpackage

/* src/feg_queue.sv */
// short fifo between the item front end and the envelope engine
`timescale 1ns / 1ps
module feg_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end
endmodule

/* src/feg_engine.sv */
// envelope engine: point table, serial search, serial divide, gain multiply
`timescale 1ns / 1ps
module feg_engine #(
    parameter int TABLE_DEPTH    = 16,
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    input  logic [1:0]                    i_mode,
    input  logic [feg_pkg::CLK_BITS-1:0]  i_at,
    input  logic [feg_pkg::CLK_BITS-1:0]  i_to,
    input  logic [GAIN_FRAC_BITS+1:0]     i_gain,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic signed [SAMPLE_BITS-1:0] o_left,
    output logic signed [SAMPLE_BITS-1:0] o_right,
    output logic [GAIN_FRAC_BITS+1:0]     o_gain,
    output logic [1:0]                    o_status
);
    import feg_pkg::*;

    localparam int GB = GAIN_FRAC_BITS + 2;
    localparam int IB = $clog2(TABLE_DEPTH);
    localparam int CB = $clog2(TABLE_DEPTH + 1);
    localparam int NB = GB + CLK_BITS;          // interpolation product width
    localparam int DB = $clog2(GB + 1);
    localparam int PB = SAMPLE_BITS + GB;
    localparam logic [GB-1:0] UNITY = {2'b01, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] LIM_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] LIM_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_FS_A = 5'd1;
    localparam logic [4:0] S_FS_B = 5'd2;
    localparam logic [4:0] S_FSEG = 5'd3;
    localparam logic [4:0] S_P0_A = 5'd4;
    localparam logic [4:0] S_P0_B = 5'd5;
    localparam logic [4:0] S_P1_A = 5'd6;
    localparam logic [4:0] S_P1_B = 5'd7;
    localparam logic [4:0] S_DMUL = 5'd8;
    localparam logic [4:0] S_DIV  = 5'd9;
    localparam logic [4:0] S_GSET = 5'd10;
    localparam logic [4:0] S_MUL  = 5'd11;
    localparam logic [4:0] S_SCL  = 5'd12;
    localparam logic [4:0] S_SAT  = 5'd13;
    localparam logic [4:0] S_PR_A = 5'd14;
    localparam logic [4:0] S_PR_B = 5'd15;
    localparam logic [4:0] S_RM_A = 5'd16;
    localparam logic [4:0] S_RM_B = 5'd17;
    localparam logic [4:0] S_IS_A = 5'd18;
    localparam logic [4:0] S_IS_B = 5'd19;
    localparam logic [4:0] S_SH_A = 5'd20;
    localparam logic [4:0] S_SH_B = 5'd21;
    localparam logic [4:0] S_IWR  = 5'd22;
    localparam logic [4:0] S_NEXT = 5'd23;
    localparam logic [4:0] S_OUT  = 5'd24;

    // fade-to progress
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // point table memories, one write and one registered read port each
    logic [CLK_BITS-1:0] r_clk_mem [TABLE_DEPTH];
    logic [GB-1:0]       r_gain_mem [TABLE_DEPTH];
    logic [CLK_BITS-1:0] r_rd_clk;
    logic [GB-1:0]       r_rd_gain;
    logic [IB-1:0]       rd_addr, wr_addr;
    logic                wr_en;
    logic [CLK_BITS-1:0] wr_clk;
    logic [GB-1:0]       wr_gain;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_clk_mem[wr_addr]  <= wr_clk;
            r_gain_mem[wr_addr] <= wr_gain;
        end
        r_rd_clk  <= r_clk_mem[rd_addr];
        r_rd_gain <= r_gain_mem[rd_addr];
    end

    logic [4:0]          r_state;
    logic [CB-1:0]       r_count;
    logic [GB-1:0]       r_held;
    logic [CB-1:0]       r_idx, r_wi;    // scan read and write indexes
    logic [CB-1:0]       r_pos;          // insert position
    logic                r_grow;         // insert adds a new entry
    logic [1:0]          r_mode;
    logic [CLK_BITS-1:0] r_at, r_to, r_key;
    logic [GB-1:0]       r_gv, r_kgain;
    logic [1:0]          r_phase;
    logic                r_fail;
    logic signed [SAMPLE_BITS-1:0] r_l, r_r;
    logic [CB-1:0]       r_below;
    logic [CB-1:0]       r_pk;           // prune shift amount
    logic [CLK_BITS-1:0] r_c0, r_span, r_off;
    logic [GB-1:0]       r_g0, r_dg;
    logic                r_down;
    logic [CLK_BITS:0]   r_rem;
    logic [GB-1:0]       r_q;
    logic [DB-1:0]       r_dcnt;
    logic [GB-1:0]       r_g;
    logic [PB-1:0]       r_pl, r_pr;
    logic                r_nl, r_nr;
    logic signed [SAMPLE_BITS-1:0] r_xl, r_xr;
    logic [GB-1:0]       r_xg;
    logic [1:0]          r_xst;
    logic                r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_ol, r_or;
    logic [GB-1:0]       r_og;
    logic [1:0]          r_ost;
    logic                out_load;

    assign o_res_valid = r_ovalid;
    assign o_left = r_ol;
    assign o_right = r_or;
    assign o_gain = r_og;
    assign o_status = r_ost;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_res_ready);

    // saturation helper
    function automatic logic [SAMPLE_BITS:0] sat_one(input logic [PB-1:0] m, input logic neg);
        logic [SAMPLE_BITS-1:0] v;
        logic s;
        begin
            s = 1'b0;
            if (neg) begin
                if (m > PB'(LIM_NEG)) begin
                    v = LIM_NEG;
                    s = 1'b1;
                end else begin
                    v = SAMPLE_BITS'(-m);
                end
            end else begin
                if (m > PB'(LIM_POS)) begin
                    v = LIM_POS;
                    s = 1'b1;
                end else begin
                    v = SAMPLE_BITS'(m);
                end
            end
            sat_one = {s, v};
        end
    endfunction

    logic [NB-1:0] prod;
    logic [CLK_BITS:0] rem_sh;
    logic [SAMPLE_BITS-1:0] abs_l, abs_r;
    logic [PB-1:0] mag_l, mag_r, rnd_l, rnd_r;
    logic [PB:0] rounded_l, rounded_r;
    logic rm_keep;
    logic [SAMPLE_BITS:0] sl, sr;

    always_comb begin
        prod = {{CLK_BITS{1'b0}}, r_dg} * {{GB{1'b0}}, r_off};
        rem_sh = {r_rem[CLK_BITS-1:0], r_q[GB-1]};
        abs_l = r_l[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_l) : SAMPLE_BITS'(r_l);
        abs_r = r_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_r) : SAMPLE_BITS'(r_r);
        mag_l = {{GB{1'b0}}, abs_l} * {{SAMPLE_BITS{1'b0}}, r_g};
        mag_r = {{GB{1'b0}}, abs_r} * {{SAMPLE_BITS{1'b0}}, r_g};
        // round half away from zero on the magnitude
        rounded_l = ({1'b0, r_pl} + ((PB+1)'(1) << (GAIN_FRAC_BITS-1))) >> GAIN_FRAC_BITS;
        rounded_r = ({1'b0, r_pr} + ((PB+1)'(1) << (GAIN_FRAC_BITS-1))) >> GAIN_FRAC_BITS;
        rnd_l = rounded_l[PB-1:0];
        rnd_r = rounded_r[PB-1:0];
        rm_keep = !(r_rd_clk >= r_at && r_rd_clk < r_to);
        sl = sat_one(r_pl, r_nl);
        sr = sat_one(r_pr, r_nr);
    end

    // memory port control
    always_comb begin
        rd_addr = IB'(r_idx);
        wr_en = 1'b0;
        wr_addr = IB'(r_wi);
        wr_clk = r_rd_clk;
        wr_gain = r_rd_gain;
        case (r_state)
            S_PR_B, S_SH_B: begin
                wr_en = 1'b1;
            end
            S_RM_B: begin
                wr_en = rm_keep;
            end
            S_IWR: begin
                wr_en = 1'b1;
                wr_clk = r_key;
                wr_gain = r_kgain;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_held <= UNITY;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_mode <= i_mode;
                        r_at <= i_at;
                        r_to <= i_to;
                        r_gv <= i_gain;
                        r_l <= i_left;
                        r_r <= i_right;
                        r_key <= i_at;
                        r_kgain <= i_gain;
                        r_fail <= 1'b0;
                        r_phase <= PH_FIRST;
                        r_grow <= 1'b0;
                        r_idx <= '0;
                        r_wi <= '0;
                        case (i_mode)
                            MODE_FRAME: r_state <= S_FS_A;
                            MODE_ADD: r_state <= S_IS_A;
                            default: begin
                                r_state <= (i_at < i_to) ? S_RM_A : S_NEXT;
                            end
                        endcase
                    end
                end
                // count points at or before the frame clock
                S_FS_A: begin
                    if (r_idx == r_count) begin
                        r_below <= r_idx;
                        r_state <= S_FSEG;
                    end else begin
                        r_state <= S_FS_B;
                    end
                end
                S_FS_B: begin
                    if (r_rd_clk <= r_at) begin
                        r_idx <= r_idx + CB'(1);
                        r_state <= S_FS_A;
                    end else begin
                        r_below <= r_idx;
                        r_state <= S_FSEG;
                    end
                end
                S_FSEG: begin
                    if (r_below != '0 && r_below != r_count) begin
                        r_idx <= r_below - CB'(1);
                        r_state <= S_P0_A;
                    end else begin
                        r_g <= r_held;
                        r_state <= S_MUL;
                    end
                end
                S_P0_A: r_state <= S_P0_B;
                S_P0_B: begin
                    r_c0 <= r_rd_clk;
                    r_g0 <= r_rd_gain;
                    r_idx <= r_below;
                    r_state <= S_P1_A;
                end
                S_P1_A: r_state <= S_P1_B;
                S_P1_B: begin
                    r_held <= r_rd_gain;
                    r_down <= r_rd_gain < r_g0;
                    r_dg <= (r_rd_gain < r_g0) ? r_g0 - r_rd_gain : r_rd_gain - r_g0;
                    r_span <= r_rd_clk - r_c0;
                    r_off <= r_at - r_c0;
                    r_state <= S_DMUL;
                end
                // offset is below the span, so the top bits start below the divisor
                S_DMUL: begin
                    r_rem <= {1'b0, prod[NB-1:GB]};
                    r_q <= prod[GB-1:0];
                    r_dcnt <= '0;
                    r_state <= S_DIV;
                end
                // one quotient bit a cycle
                S_DIV: begin
                    if (rem_sh >= {1'b0, r_span}) begin
                        r_rem <= rem_sh - {1'b0, r_span};
                        r_q <= {r_q[GB-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_q <= {r_q[GB-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + DB'(1);
                    if (r_dcnt == DB'(GB - 1)) begin
                        r_state <= S_GSET;
                    end
                end
                S_GSET: begin
                    r_g <= r_down ? r_g0 - r_q : r_g0 + r_q;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pl <= mag_l;
                    r_pr <= mag_r;
                    r_nl <= r_l[SAMPLE_BITS-1];
                    r_nr <= r_r[SAMPLE_BITS-1];
                    r_state <= S_SCL;
                end
                S_SCL: begin
                    r_pl <= rnd_l;
                    r_pr <= rnd_r;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_xl <= sl[SAMPLE_BITS-1:0];
                    r_xr <= sr[SAMPLE_BITS-1:0];
                    r_xg <= r_g;
                    r_xst <= (sl[SAMPLE_BITS] || sr[SAMPLE_BITS]) ? STAT_SAT : STAT_OK;
                    if (r_below >= CB'(3)) begin
                        r_pk <= r_below - CB'(2);
                        r_idx <= r_below - CB'(2);
                        r_wi <= '0;
                        r_state <= S_PR_A;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                // copy entries down by k
                S_PR_A: begin
                    if (r_idx == r_count) begin
                        r_count <= r_count - r_pk;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PR_B;
                    end
                end
                S_PR_B: begin
                    r_idx <= r_idx + CB'(1);
                    r_wi <= r_wi + CB'(1);
                    r_state <= S_PR_A;
                end
                // compact the table, skipping entries in the range
                S_RM_A: begin
                    if (r_idx == r_count) begin
                        r_count <= r_wi;
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_RM_B;
                    end
                end
                S_RM_B: begin
                    if (rm_keep) begin
                        r_wi <= r_wi + CB'(1);
                    end
                    r_idx <= r_idx + CB'(1);
                    r_state <= S_RM_A;
                end
                // find the first point not below the key
                S_IS_A: begin
                    if (r_idx == r_count) begin
                        if (r_count == CB'(TABLE_DEPTH)) begin
                            r_fail <= 1'b1;
                            r_state <= S_NEXT;
                        end else begin
                            r_pos <= r_idx;
                            r_wi <= r_count;
                            r_idx <= r_count - CB'(1);
                            r_grow <= 1'b1;
                            r_state <= S_SH_A;
                        end
                    end else begin
                        r_state <= S_IS_B;
                    end
                end
                S_IS_B: begin
                    if (r_rd_clk < r_key) begin
                        r_idx <= r_idx + CB'(1);
                        r_state <= S_IS_A;
                    end else if (r_rd_clk == r_key) begin
                        // same clock: replace the gain in place
                        r_wi <= r_idx;
                        r_grow <= 1'b0;
                        r_state <= S_IWR;
                    end else if (r_count == CB'(TABLE_DEPTH)) begin
                        r_fail <= 1'b1;
                        r_state <= S_NEXT;
                    end else begin
                        r_pos <= r_idx;
                        r_wi <= r_count;
                        r_idx <= r_count - CB'(1);
                        r_grow <= 1'b1;
                        r_state <= S_SH_A;
                    end
                end
                // move entries from the top down to the insert position up one place
                S_SH_A: begin
                    r_state <= (r_wi == r_pos) ? S_IWR : S_SH_B;
                end
                S_SH_B: begin
                    r_wi <= r_wi - CB'(1);
                    r_idx <= r_idx - CB'(1);
                    r_state <= S_SH_A;
                end
                S_IWR: begin
                    if (r_grow) begin
                        r_count <= r_count + CB'(1);
                    end
                    r_state <= S_NEXT;
                end
                // fade-to runs two inserts after the removal, then the result
                S_NEXT: begin
                    r_idx <= '0;
                    r_grow <= 1'b0;
                    if (r_mode == MODE_FADE && r_phase == PH_FIRST) begin
                        r_key <= r_at;
                        r_kgain <= r_held;
                        r_phase <= PH_SECOND;
                        r_state <= S_IS_A;
                    end else if (r_mode == MODE_FADE && r_phase == PH_SECOND) begin
                        r_key <= r_to;
                        r_kgain <= r_gv;
                        r_phase <= PH_DONE;
                        r_state <= S_IS_A;
                    end else begin
                        r_xl <= '0;
                        r_xr <= '0;
                        r_xg <= r_held;
                        r_xst <= r_fail ? STAT_FULL : STAT_OK;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ol <= r_xl;
            r_or <= r_xr;
            r_og <= r_xg;
            r_ost <= r_xst;
        end
    end

    ap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(TABLE_DEPTH)) else $error("point count over depth");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_res_ready |=> r_ovalid && $stable({r_ol, r_or, r_og, r_ost}))
        else $error("waiting result item changed");
    ap_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= S_OUT) else $error("engine state out of range");
    ap_fail_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SAT) |-> !r_fail) else $error("frame flagged table full");
endmodule

/* src/fade_envelope_gain.sv */
// top level of the fade envelope gain block
`timescale 1ns / 1ps
// channel   dir  tdata fields (low bit up)                     tuser
// s_axis    in   at_clock, to_clock, gain_value, left, right   mode
// m_axis    out  left_out, right_out, applied_gain             status
//
// work: table scans step through the points one at a time; a frame inside a segment
// interpolates its gain in the bit-serial divider of the interpolation step, and
// old points are pruned by moving the later points down
// a command scans the table, a fade-to up to three times
// reset: i_rst_n synchronous low; table empty, held gain unity, no clearing pass
// stalls: a two-entry queue parts the input from the engine, and the result
// register lets the engine take the next item while a result waits
module fade_envelope_gain #(
    parameter int TABLE_DEPTH    = 16,
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // at_clock, to_clock, gain_value, left_in, right_in, zero fill
    input  logic [((64 + GAIN_FRAC_BITS + 2 + 2*SAMPLE_BITS + 7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // left_out, right_out, applied_gain, zero fill
    output logic [((2*SAMPLE_BITS + GAIN_FRAC_BITS + 2 + 7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [1:0] m_axis_tuser
);
    import feg_pkg::*;

    localparam int GB = GAIN_FRAC_BITS + 2;
    localparam int IN_W = 64 + GB + 2*SAMPLE_BITS;
    localparam int OUT_W = 2*SAMPLE_BITS + GB;
    localparam int OUT_TW = ((OUT_W + 7)/8)*8;
    localparam int QW = IN_W + 2;

    logic q_full, q_empty, q_pop;
    logic [QW-1:0] q_data;

    // front end: accepts items into the queue
    assign s_axis_tready = !q_full;

    feg_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  ({s_axis_tdata[IN_W-1:0], s_axis_tuser}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    logic signed [SAMPLE_BITS-1:0] ol, orr;
    logic [GB-1:0] og;

    feg_engine #(
        .TABLE_DEPTH(TABLE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .o_cmd_pop   (q_pop),
        .i_mode      (q_data[1:0]),
        .i_at        (q_data[33:2]),
        .i_to        (q_data[65:34]),
        .i_gain      (q_data[66+GB-1:66]),
        .i_left      (q_data[66+GB+SAMPLE_BITS-1:66+GB]),
        .i_right     (q_data[66+GB+2*SAMPLE_BITS-1:66+GB+SAMPLE_BITS]),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_left      (ol),
        .o_right     (orr),
        .o_gain      (og),
        .o_status    (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TW'({og, orr, ol});
endmodule
